FILE: rtl/core/pbfb_pkg.sv
// ============================================================================
// pbfb_pkg : shared types and constants of the packed pixel framebuffer
// Frame geometry limits, memory size, register indexes, action and format
// codes, and the pixel location record passed from the decoder.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pbfb_pkg;

    // frame and memory geometry
    localparam int MAX_DIMENSION = 1024;
    localparam int MEM_BYTES     = 524288;
    localparam int DIM_W         = 11;                       // holds MAX_DIMENSION
    localparam int COORD_W       = $clog2(MAX_DIMENSION);    // pixel coordinate
    localparam int ROW_BYTES_W   = COORD_W;                  // holds MAX_DIMENSION / 2
    localparam int ADDR_W        = $clog2(MEM_BYTES);        // memory index
    localparam int SPAN_W        = ADDR_W + 1;               // byte counts and raw addresses

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FORMAT = 2'd2
    } pbfb_reg_t;

    // request kinds
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } pbfb_action_t;

    // pixel formats
    typedef enum logic [1:0] {
        FMT_MONO  = 2'd0,
        FMT_GRAY  = 2'd1,
        FMT_COLOR = 2'd2
    } pbfb_format_t;

    // log2 of bits per pixel; the unused format code acts as color
    localparam logic [1:0] SH_MONO  = 2'd0;
    localparam logic [1:0] SH_GRAY  = 2'd1;
    localparam logic [1:0] SH_COLOR = 2'd2;

    // pixel location decoded from a request
    typedef struct packed {
        logic              hit;      // point inside the frame
        logic              addr_ok;  // byte lies inside the memory
        logic [ADDR_W-1:0] addr;     // byte index
        logic [2:0]        slot;     // pixel position inside the byte, left first
    } pbfb_loc_t;

    function automatic logic [1:0] bpp_shift(input logic [1:0] fmt);
        logic [1:0] sh;
        case (fmt)
            FMT_MONO: sh = SH_MONO;
            FMT_GRAY: sh = SH_GRAY;
            default:  sh = SH_COLOR;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pbfb_mem.sv
// ============================================================================
// pbfb_mem : frame byte store
// Single synchronous memory, one write and one read port, registered read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pbfb_mem (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [pbfb_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]                  wr_data,
    input  wire logic                        rd_en,
    input  wire logic [pbfb_pkg::ADDR_W-1:0] rd_addr,
    output logic      [7:0]                  rd_data
);
    import pbfb_pkg::*;

    logic [7:0] mem [MEM_BYTES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pbfb_locate.sv
// ============================================================================
// pbfb_locate : pixel position decoder
// Clips a signed point to the frame and forms byte index and pixel slot.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pbfb_locate (
    input  wire logic signed [15:0]                      pos_x,
    input  wire logic signed [15:0]                      pos_y,
    input  wire logic        [pbfb_pkg::DIM_W-1:0]       frame_w,
    input  wire logic        [pbfb_pkg::DIM_W-1:0]       frame_h,
    input  wire logic        [pbfb_pkg::ROW_BYTES_W-1:0] row_bytes,
    input  wire logic        [1:0]                       sh,
    output pbfb_pkg::pbfb_loc_t                          loc
);
    import pbfb_pkg::*;

    logic               x_ok;
    logic               y_ok;
    logic [COORD_W-1:0] ux;
    logic [COORD_W-1:0] uy;
    logic [COORD_W-1:0] col;
    logic [SPAN_W-1:0]  prod;
    logic [SPAN_W-1:0]  addr_full;

    always_comb
    begin
        x_ok = !pos_x[15] && (pos_x[14:0] < 15'(frame_w));
        y_ok = !pos_y[15] && (pos_y[14:0] < 15'(frame_h));
        ux   = pos_x[COORD_W-1:0];
        uy   = pos_y[COORD_W-1:0];

        case (sh)
            SH_MONO:
            begin
                col      = COORD_W'(ux >> 3);
                loc.slot = ux[2:0];
            end
            SH_GRAY:
            begin
                col      = COORD_W'(ux >> 2);
                loc.slot = {1'b0, ux[1:0]};
            end
            default:
            begin
                col      = COORD_W'(ux >> 1);
                loc.slot = {2'b00, ux[0]};
            end
        endcase

        prod        = SPAN_W'(uy * row_bytes);
        addr_full   = prod + SPAN_W'(col);
        loc.hit     = x_ok && y_ok;
        loc.addr_ok = addr_full < SPAN_W'(MEM_BYTES);
        loc.addr    = addr_full[ADDR_W-1:0];
    end

endmodule

`default_nettype wire

FILE: rtl/core/packed_pixel_framebuffer.sv
// ============================================================================
// packed_pixel_framebuffer : byte-packed display framebuffer
// Pixel write (read-modify-write of one byte), pixel read and frame clear
// over a single-port-per-direction byte memory; mono, gray and color formats.
// ============================================================================
//
//  channel   direction  payload                                  transaction
//  s_axis    in         tuser: action; tdata: pos_x,pos_y,color  one request
//  m_axis    out        tuser: in_bounds; tdata: pixel_value     one result
//  cfg       in         cfg_index, cfg_data                      register write
//
//  write and read: the byte is read at the accepting edge and the modified
//  byte is written back in the modify step, once the output register is free
//  clear writes row_bytes * height bytes, at most the memory, one byte per cycle
//  reset clears control and sets width 1, height 1, mono; the memory is not
//  cleared, a clear request must come before any pixel access
//  a result waiting on m_axis holds the block in its last step until taken
//
`timescale 1ns / 1ps
`default_nettype none

module packed_pixel_framebuffer (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], color[39:32]
    input  wire logic [1:0]  s_axis_tuser,   // action[1:0]

    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,   // pixel_value[3:0], zero[7:4]
    output logic             m_axis_tuser,   // in_bounds[0]

    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);
    import pbfb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_CLEAR,
        ST_REPORT
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers and derived geometry
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]       width_reg,  width_next;
    logic [DIM_W-1:0]       height_reg, height_next;
    logic [1:0]             format_reg, format_next;
    logic [DIM_W-1:0]       w_eff_reg,  w_eff_next;
    logic [DIM_W-1:0]       h_eff_reg,  h_eff_next;
    logic [ROW_BYTES_W-1:0] rb_reg,     rb_next;
    logic [1:0]             sh_reg,     sh_next;
    logic [DIM_W:0]         rb_sum;

    assign cfg_ready = 1'b1;

    // derived values follow the next register values so a request right
    // after a write already sees the new geometry
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        format_next = format_reg;
        if (cfg_valid)
        begin
            if (cfg_index == REG_WIDTH)  width_next  = cfg_data;
            if (cfg_index == REG_HEIGHT) height_next = cfg_data;
            if (cfg_index == REG_FORMAT) format_next = cfg_data[1:0];
        end

        // zero counts as one, oversize saturates
        if (width_next == '0)
            w_eff_next = DIM_W'(1);
        else if (width_next > DIM_W'(MAX_DIMENSION))
            w_eff_next = DIM_W'(MAX_DIMENSION);
        else
            w_eff_next = width_next;

        if (height_next == '0)
            h_eff_next = DIM_W'(1);
        else if (height_next > DIM_W'(MAX_DIMENSION))
            h_eff_next = DIM_W'(MAX_DIMENSION);
        else
            h_eff_next = height_next;

        sh_next = bpp_shift(format_next);

        // row length in bytes, rounded up
        case (sh_next)
            SH_MONO:
            begin
                rb_sum  = {1'b0, w_eff_next} + (DIM_W+1)'(7);
                rb_next = ROW_BYTES_W'(rb_sum >> 3);
            end
            SH_GRAY:
            begin
                rb_sum  = {1'b0, w_eff_next} + (DIM_W+1)'(3);
                rb_next = ROW_BYTES_W'(rb_sum >> 2);
            end
            default:
            begin
                rb_sum  = {1'b0, w_eff_next} + (DIM_W+1)'(1);
                rb_next = ROW_BYTES_W'(rb_sum >> 1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            format_reg <= FMT_MONO;
            w_eff_reg  <= DIM_W'(1);
            h_eff_reg  <= DIM_W'(1);
            rb_reg     <= ROW_BYTES_W'(1);
            sh_reg     <= SH_MONO;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            format_reg <= format_next;
            w_eff_reg  <= w_eff_next;
            h_eff_reg  <= h_eff_next;
            rb_reg     <= rb_next;
            sh_reg     <= sh_next;
        end
    end

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    logic signed [15:0] in_pos_x;
    logic signed [15:0] in_pos_y;
    logic        [7:0]  in_color;
    logic        [1:0]  in_action;
    logic               in_accept;
    pbfb_loc_t          loc;

    assign in_pos_x  = s_axis_tdata[15:0];
    assign in_pos_y  = s_axis_tdata[31:16];
    assign in_color  = s_axis_tdata[39:32];
    assign in_action = s_axis_tuser;

    pbfb_locate u_locate (
        .pos_x     (in_pos_x),
        .pos_y     (in_pos_y),
        .frame_w   (w_eff_reg),
        .frame_h   (h_eff_reg),
        .row_bytes (rb_reg),
        .sh        (sh_reg),
        .loc       (loc)
    );

    // clear span and fill pattern
    logic [SPAN_W+1:0] clr_total;
    logic [SPAN_W-1:0] clr_last;
    logic [7:0]        fill_byte;

    always_comb
    begin
        clr_total = (SPAN_W+2)'(rb_reg * h_eff_reg);
        if (clr_total > (SPAN_W+2)'(MEM_BYTES))
            clr_total = (SPAN_W+2)'(MEM_BYTES);
        clr_last = SPAN_W'(clr_total - (SPAN_W+2)'(1));

        case (sh_reg)
            SH_MONO:  fill_byte = (in_color != 8'h00) ? 8'hFF : 8'h00;
            SH_GRAY:  fill_byte = {4{in_color[1:0]}};
            default:  fill_byte = {2{in_color[3:0]}};
        endcase
    end

    // ------------------------------------------------------------------
    // control, item registers and result register
    // ------------------------------------------------------------------
    state_t            state_reg;
    logic              is_write_reg;
    logic              is_read_reg;
    logic              hit_reg;
    logic              addr_ok_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [2:0]        slot_reg;
    logic [7:0]        color_reg;
    logic [7:0]        fill_reg;
    logic [SPAN_W-1:0] clr_cnt_reg;
    logic [SPAN_W-1:0] clr_last_reg;
    logic              out_valid_reg;
    logic [3:0]        out_pixel_reg;
    logic              out_inb_reg;

    logic              out_free;
    logic              out_load;
    logic [7:0]        rd_byte;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // a new result enters the output register this cycle
    assign out_load      = ((state_reg == ST_MODIFY) || (state_reg == ST_REPORT)) && out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'h0, out_pixel_reg};
    assign m_axis_tuser  = out_inb_reg;

    // ------------------------------------------------------------------
    // byte modify: mask and shift for the pixel slot
    // ------------------------------------------------------------------
    logic [2:0] pix_shift;
    logic [3:0] pix_mask;
    logic [3:0] pix_color;
    logic [7:0] byte_mask;
    logic [7:0] new_byte;
    logic [3:0] old_pixel;

    always_comb
    begin
        case (sh_reg)
            SH_MONO:
            begin
                pix_shift = 3'd7 - slot_reg;
                pix_mask  = 4'h1;
                pix_color = {3'b000, (color_reg != 8'h00)};
            end
            SH_GRAY:
            begin
                pix_shift = 3'd6 - {slot_reg[1:0], 1'b0};
                pix_mask  = 4'h3;
                pix_color = {2'b00, color_reg[1:0]};
            end
            default:
            begin
                pix_shift = slot_reg[0] ? 3'd0 : 3'd4;
                pix_mask  = 4'hF;
                pix_color = color_reg[3:0];
            end
        endcase
        byte_mask = 8'({4'h0, pix_mask} << pix_shift);
        new_byte  = (rd_byte & ~byte_mask) | (8'({4'h0, pix_color} << pix_shift) & byte_mask);
        old_pixel = 4'((rd_byte & byte_mask) >> pix_shift);
    end

    // ------------------------------------------------------------------
    // memory ports
    // ------------------------------------------------------------------
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_reg[ADDR_W-1:0];
            mem_wr_data = fill_reg;
        end
        else
        begin
            // write back only once, on the cycle the result is handed over
            mem_wr_en   = (state_reg == ST_MODIFY) && out_free && is_write_reg
                          && hit_reg && addr_ok_reg;
            mem_wr_addr = addr_reg;
            mem_wr_data = new_byte;
        end
    end

    pbfb_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (in_accept),
        .rd_addr (loc.addr),
        .rd_data (rd_byte)
    );

    // ------------------------------------------------------------------
    // state machine
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_pixel_reg <= 4'h0;
            out_inb_reg   <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            // load a new result, or drop the one whose transaction completes
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        case (in_action)
                            ACT_WRITE, ACT_READ: state_reg <= ST_MODIFY;
                            ACT_CLEAR:           state_reg <= ST_CLEAR;
                            default:             state_reg <= ST_REPORT;
                        endcase
                        clr_cnt_reg <= '0;
                    end
                end

                ST_MODIFY:
                begin
                    if (out_free)
                    begin
                        out_inb_reg   <= hit_reg;
                        out_pixel_reg <= (is_read_reg && hit_reg && addr_ok_reg)
                                         ? old_pixel : 4'h0;
                        state_reg     <= ST_IDLE;
                    end
                end

                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + SPAN_W'(1);
                    if (clr_cnt_reg == clr_last_reg)
                        state_reg <= ST_REPORT;
                end

                ST_REPORT:
                begin
                    // clears and unknown actions report zero and out of frame
                    if (out_free)
                    begin
                        out_inb_reg   <= 1'b0;
                        out_pixel_reg <= 4'h0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // request payload captured at acceptance
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            is_write_reg <= (in_action == ACT_WRITE);
            is_read_reg  <= (in_action == ACT_READ);
            hit_reg      <= loc.hit;
            addr_ok_reg  <= loc.addr_ok;
            addr_reg     <= loc.addr;
            slot_reg     <= loc.slot;
            color_reg    <= in_color;
            fill_reg     <= fill_byte;
            clr_last_reg <= clr_last;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ============================================================================
// testbench : self-checking bench for the packed pixel framebuffer
// Streams pixel write, read, clear and unknown requests under random back-pressure,
// predicts every result from a shadow copy of the frame memory and the
// register settings, and checks each result transaction in order.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    import pbfb_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] ACT_NONE  = 2'd3;    // unknown action, no effect
    localparam logic [1:0] FMT_SPARE = 2'd3;    // unused format, acts as color

    localparam int IDLE_PCT    = 35;
    localparam int HOLD_CYCLES = 300;           // long receiver hold-off
    localparam int CLEAR_CAP   = 4096;          // pixels; bigger frames skip random clears

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  color;
    } pixel_request_t;

    typedef struct packed {
        logic [3:0] pixel_value;
        logic       in_bounds;
    } pixel_reply_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // pos_x[15:0], pos_y[31:16], color[39:32]
    logic [1:0]  s_axis_tuser = '0;     // action[1:0]

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // pixel_value[3:0], zero[7:4]
    logic        m_axis_tuser;          // in_bounds[0]

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    packed_pixel_framebuffer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // shared bench state
    // ------------------------------------------------------------------------
    pixel_request_t request_q[$];       // requests waiting for the driver
    pixel_reply_t   reply_q[$];         // predicted results, oldest first
    int             requests_sent  = 0; // pushed into request_q
    int             requests_taken = 0; // accepted by the block
    int             cfg_writes     = 0; // register write transactions seen
    int             fault_count    = 0;
    bit             req_fired      = 1'b0;
    int             src_gap_pct    = IDLE_PCT;
    int             sink_gap_pct   = IDLE_PCT;
    int             holds_asked    = 0;

    // shadow of the frame and of the registers, updated on accepted transactions
    bit [7:0]       frame_shadow [0:MEM_BYTES-1];
    logic [10:0]    cfg_width  = 11'd1;
    logic [10:0]    cfg_height = 11'd1;
    logic [1:0]     cfg_format = FMT_MONO;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    // register value as the block uses it: zero means one, large values saturate
    function automatic int dim_of(input logic [10:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_DIMENSION)
            return MAX_DIMENSION;
        return int'(raw);
    endfunction

    // log2 of the pixel width; the spare format code behaves as color
    function automatic logic [1:0] shift_of(input logic [1:0] fmt);
        if (fmt == FMT_MONO)
            return SH_MONO;
        if (fmt == FMT_GRAY)
            return SH_GRAY;
        return SH_COLOR;
    endfunction

    // applies one request to the shadow frame and returns the result it causes
    function automatic pixel_reply_t render_request(input pixel_request_t rq);
        pixel_reply_t rp;
        logic [1:0]   sh;
        int           w, h, ppb, pbits, rb, addr, slot, bitpos, total, px, py;
        logic [7:0]   mask, fill, ink, cur;
        rp    = '0;
        w     = dim_of(cfg_width);
        h     = dim_of(cfg_height);
        sh    = shift_of(cfg_format);
        pbits = 1 << sh;
        ppb   = 8 >> sh;
        rb    = (w + ppb - 1) / ppb;
        px    = int'($signed(rq.pos_x));
        py    = int'($signed(rq.pos_y));
        if (rq.action == ACT_CLEAR)
        begin
            // repeat the color across the byte; mono is all or nothing
            if (sh == SH_MONO)
                fill = (rq.color != 0) ? 8'hFF : 8'h00;
            else if (sh == SH_GRAY)
                fill = {4{rq.color[1:0]}};
            else
                fill = {2{rq.color[3:0]}};
            total = rb * h;
            if (total > MEM_BYTES)
                total = MEM_BYTES;
            for (int i = 0; i < total; i++)
                frame_shadow[i] = fill;
        end
        else if (rq.action == ACT_WRITE || rq.action == ACT_READ)
        begin
            if (px >= 0 && py >= 0 && px < w && py < h)
            begin
                rp.in_bounds = 1'b1;
                addr   = px / ppb + py * rb;
                slot   = px % ppb;
                bitpos = 8 - pbits * (slot + 1);   // leftmost pixel in the top bits
                mask   = 8'(((1 << pbits) - 1) << bitpos);
                if (addr < MEM_BYTES)
                begin
                    cur = frame_shadow[addr];
                    if (rq.action == ACT_WRITE)
                    begin
                        if (sh == SH_MONO)
                            ink = (rq.color != 0) ? 8'h01 : 8'h00;
                        else
                            ink = rq.color & 8'((1 << pbits) - 1);
                        frame_shadow[addr] = (cur & ~mask) | (8'(ink << bitpos) & mask);
                    end
                    else
                        rp.pixel_value = 4'((cur & mask) >> bitpos);
                end
            end
        end
        return rp;
    endfunction

    // ------------------------------------------------------------------------
    // monitor: samples every handshake at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_request_t rq;
        pixel_reply_t   exp_rp;
        if (rst_n)
        begin
            // register write transaction
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WIDTH:  cfg_width  = cfg_data;
                    REG_HEIGHT: cfg_height = cfg_data;
                    REG_FORMAT: cfg_format = cfg_data[1:0];
                    default:    ;
                endcase
                cfg_writes++;
            end
            // request transaction: predict its result right away
            if (s_axis_tvalid && s_axis_tready)
            begin
                rq.action = s_axis_tuser;
                rq.pos_x  = s_axis_tdata[15:0];
                rq.pos_y  = s_axis_tdata[31:16];
                rq.color  = s_axis_tdata[39:32];
                reply_q.push_back(render_request(rq));
                requests_taken++;
                req_fired = 1'b1;
            end
            // result transaction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (reply_q.size() == 0)
                begin
                    $display("%0t: unexpected result: pixel_value %0h in_bounds %0b",
                             $time, m_axis_tdata, m_axis_tuser);
                    fault_count++;
                end
                else
                begin
                    exp_rp = reply_q.pop_front();
                    if (m_axis_tdata !== {4'h0, exp_rp.pixel_value})
                    begin
                        $display("%0t: pixel_value mismatch: expected %0h, actual %0h",
                                 $time, {4'h0, exp_rp.pixel_value}, m_axis_tdata);
                        fault_count++;
                    end
                    if (m_axis_tuser !== exp_rp.in_bounds)
                    begin
                        $display("%0t: in_bounds mismatch: expected %0b, actual %0b",
                                 $time, exp_rp.in_bounds, m_axis_tuser);
                        fault_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver: offers queued requests, changes inputs at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        pixel_request_t rq;
        // the bus is free when nothing is offered or the last offer was taken
        if (!s_axis_tvalid || req_fired)
        begin
            if (request_q.size() > 0 && $urandom_range(99) >= src_gap_pct)
            begin
                rq = request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= rq.action;
                s_axis_tdata  <= {rq.color, rq.pos_y, rq.pos_x};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        req_fired = 1'b0;
    end

    // ------------------------------------------------------------------------
    // receiver: random back-pressure plus an occasional long hold-off
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        int holds_started;
        int hold_left;
        if (holds_started != holds_asked)
        begin
            holds_started++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic pixel_request_t pixel_cmd(input logic [1:0] action, input int x,
                                                 input int y, input logic [7:0] color);
        pixel_request_t rq;
        rq.action = action;
        rq.pos_x  = 16'(x);
        rq.pos_y  = 16'(y);
        rq.color  = color;
        return rq;
    endfunction

    task automatic queue_request(input pixel_request_t rq);
        request_q.push_back(rq);
        requests_sent++;
    endtask

    // returns once every request is taken and every result has come back
    task automatic wait_drained();
        while (requests_sent != requests_taken || reply_q.size() != 0)
            @(negedge clk);
    endtask

    // one register write transaction; cfg_valid stays high for the caller
    task automatic program_register(input pbfb_reg_t idx, input logic [10:0] value);
        int target;
        target = cfg_writes + 1;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (cfg_writes < target);
    endtask

    // registers change only while the block is idle
    task automatic configure(input logic [10:0] w_raw, input logic [10:0] h_raw,
                             input logic [1:0] fmt);
        wait_drained();
        program_register(REG_WIDTH, w_raw);
        program_register(REG_HEIGHT, h_raw);
        program_register(REG_FORMAT, {9'd0, fmt});
        cfg_valid <= 1'b0;
    endtask

    // random request, mostly inside the frame, some on the edges, some anywhere
    function automatic pixel_request_t draw_request(input int w, input int h);
        pixel_request_t rq;
        int             pick;
        pick = $urandom_range(99);
        if (pick < 46)
            rq.action = ACT_WRITE;
        else if (pick < 90)
            rq.action = ACT_READ;
        else if (pick < 95)
            rq.action = (w * h <= CLEAR_CAP) ? ACT_CLEAR : ACT_READ;
        else
            rq.action = ACT_NONE;
        rq.pos_x = 16'($urandom_range(w - 1));
        rq.pos_y = 16'($urandom_range(h - 1));
        pick = $urandom_range(99);
        if (pick >= 90)
        begin
            rq.pos_x = 16'($urandom());
            rq.pos_y = 16'($urandom());
        end
        else if (pick >= 80)
        begin
            // just past one of the four borders
            case ($urandom_range(3))
                0:       rq.pos_x = 16'(w);
                1:       rq.pos_x = 16'(-1 - int'($urandom_range(2)));
                2:       rq.pos_y = 16'(h);
                default: rq.pos_y = 16'hFFFF;
            endcase
        end
        rq.color = ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(255));
        return rq;
    endfunction

    // new settings, a clear so every byte of the frame is defined, then traffic;
    // halfway the sender waits for all results before going on
    task automatic run_phase(input logic [10:0] w_raw, input logic [10:0] h_raw,
                             input logic [1:0] fmt, input int n_items,
                             input bit quiet, input bit hold);
        int w, h;
        configure(w_raw, h_raw, fmt);
        w = dim_of(w_raw);
        h = dim_of(h_raw);
        src_gap_pct  = quiet ? 0 : IDLE_PCT;
        sink_gap_pct = quiet ? 0 : IDLE_PCT;
        queue_request(pixel_cmd(ACT_CLEAR, $urandom_range(w - 1), $urandom_range(h - 1),
                                8'($urandom_range(255))));
        for (int i = 1; i < n_items; i++)
        begin
            if (i == n_items / 2)
            begin
                wait_drained();
                if (hold)
                    holds_asked++;
            end
            queue_request(draw_request(w, h));
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, 1 x 1 mono: mono write and clear rules, clipping
        queue_request(pixel_cmd(ACT_CLEAR, 0, 0, 8'h5A));          // nonzero fills ones
        queue_request(pixel_cmd(ACT_READ, 0, 0, 8'h00));
        queue_request(pixel_cmd(ACT_WRITE, 0, 0, 8'h00));          // color zero clears the bit
        queue_request(pixel_cmd(ACT_READ, 0, 0, 8'hFF));
        queue_request(pixel_cmd(ACT_WRITE, 0, 0, 8'h80));          // any other value sets it
        queue_request(pixel_cmd(ACT_READ, 0, 0, 8'h00));
        queue_request(pixel_cmd(ACT_CLEAR, 0, 0, 8'h00));          // zero fills zeros
        queue_request(pixel_cmd(ACT_READ, 0, 0, 8'h00));
        queue_request(pixel_cmd(ACT_READ, 1, 0, 8'h00));           // just right of the frame
        queue_request(pixel_cmd(ACT_READ, -1, 0, 8'h00));
        queue_request(pixel_cmd(ACT_WRITE, 32767, -32768, 8'hFF)); // clipped, no effect
        queue_request(pixel_cmd(ACT_READ, 0, 0, 8'h00));
        queue_request(pixel_cmd(ACT_NONE, 0, 0, 8'hFF));           // unknown action

        // 11 x 3 gray: packing order inside a byte, bottom right corner
        configure(11'd11, 11'd3, FMT_GRAY);
        queue_request(pixel_cmd(ACT_CLEAR, 0, 0, 8'hFE));
        queue_request(pixel_cmd(ACT_WRITE, 0, 0, 8'hFC));          // high bits masked off
        queue_request(pixel_cmd(ACT_WRITE, 1, 0, 8'hFD));
        queue_request(pixel_cmd(ACT_WRITE, 3, 0, 8'hFF));
        queue_request(pixel_cmd(ACT_READ, 0, 0, 8'h00));
        queue_request(pixel_cmd(ACT_READ, 1, 0, 8'h00));
        queue_request(pixel_cmd(ACT_READ, 2, 0, 8'h00));           // still the clear pattern
        queue_request(pixel_cmd(ACT_READ, 3, 0, 8'h00));
        queue_request(pixel_cmd(ACT_WRITE, 10, 2, 8'h01));
        queue_request(pixel_cmd(ACT_READ, 10, 2, 8'h00));
        queue_request(pixel_cmd(ACT_READ, 11, 2, 8'h00));
        queue_request(pixel_cmd(ACT_READ, 10, 3, 8'h00));

        // register extremes: zero sizes, saturating sizes, spare format, full frame
        run_phase(11'd0, 11'd0, FMT_COLOR, 40, 1'b0, 1'b0);
        run_phase(11'd2047, 11'd1, FMT_SPARE, 60, 1'b0, 1'b0);
        run_phase(11'd1, 11'd1024, FMT_MONO, 60, 1'b0, 1'b0);
        run_phase(11'd1024, 11'd1024, FMT_MONO, 40, 1'b0, 1'b0);
        run_phase(11'd1025, 11'd2, FMT_GRAY, 40, 1'b0, 1'b0);

        // small random frames; one phase without idling, one with a long hold-off
        for (int p = 0; p < 9; p++)
            run_phase(11'($urandom_range(40, 1)), 11'($urandom_range(24, 1)),
                      2'($urandom_range(3)), 100, p == 2, p == 5);

        wait_drained();
        repeat (16) @(negedge clk);     // catch any stray result
        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #60_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
